[src/brd_pkg.sv]
// Shared types and constants for the binomial row deviance block.
package brd_pkg;

    localparam int          SUM_Y_W   = 28;
    localparam int          SUM_N_W   = 29;
    localparam int          ACC_W     = 56;
    localparam int          DEV_W     = 48;
    localparam int          LOG2_FRAC = 40;
    localparam int          EXP_W     = 6;
    localparam logic [63:0] LN2_Q63   = 64'h58B9_0BFB_E8E7_BCD5;
    localparam logic [63:0] SUM_Y_MAX = (64'd1 << SUM_Y_W) - 64'd1;
    localparam logic [63:0] SUM_N_MAX = (64'd1 << SUM_N_W) - 64'd1;
    localparam logic [63:0] ACC_MAX   = (64'd1 << ACC_W) - 64'd1;
    localparam logic [63:0] DEV_MAX   = (64'd1 << DEV_W) - 64'd1;

    typedef enum logic {
        ALU_LN,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } t_alu_rsp;

endpackage

[src/brd_mul.sv]
// Shared 32x32 multiplier with a registered product.
module brd_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[src/brd_alu.sv]
// Iterative log and wide multiply unit built around the shared multiplier.
module brd_alu
    import brd_pkg::*;
#(
    parameter int XW             = 29,
    parameter int LOG_FRAC_BITS  = 20
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    localparam int RND = 38 - LOG_FRAC_BITS;
    localparam int SHR = 39 - LOG_FRAC_BITS;

    typedef enum logic [2:0] {
        A_IDLE,
        A_NORM,
        A_SQ,
        A_MUL,
        A_FIN
    } t_astate;

    t_astate        r_state;
    t_alu_op        r_op;
    logic [XW-1:0]  r_m;
    logic [EXP_W-1:0] r_e;
    logic [31:0]    r_mant;
    logic [LOG2_FRAC-1:0] r_frac;
    logic [5:0]     r_cnt;
    logic           r_ph;
    logic [1:0]     r_k;
    logic [63:0]    r_a64;
    logic [63:0]    r_b64;
    logic [127:0]   r_acc;
    t_alu_rsp       r_rsp;

    logic [31:0]    mul_a;
    logic [31:0]    mul_b;
    logic [63:0]    mul_p;
    logic [32:0]    sq;
    logic [31:0]    n_mant;
    logic [LOG2_FRAC-1:0] n_frac;
    logic [31:0]    mant_init;
    logic [127:0]   part;
    logic [63:0]    hi;
    logic [63:0]    ln_val;
    logic [63:0]    mul_val;

    brd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_comb begin
        if (r_state == A_SQ) begin
            mul_a = r_mant;
            mul_b = r_mant;
        end else begin
            mul_a = r_k[1] ? r_a64[63:32] : r_a64[31:0];
            mul_b = r_k[0] ? r_b64[63:32] : r_b64[31:0];
        end
        sq        = mul_p[63:31];
        n_mant    = sq[32] ? sq[32:1] : sq[31:0];
        n_frac    = {r_frac[LOG2_FRAC-2:0], sq[32]};
        mant_init = 32'({r_m, 32'd0} >> XW);
        part      = 128'(mul_p) << (7'(r_k[1]) * 7'd32 + 7'(r_k[0]) * 7'd32);
        hi        = r_acc[127:64];
        ln_val    = (hi + (64'd1 << RND)) >> SHR;
        mul_val   = (hi != 64'd0) ? '1 : r_acc[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= A_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_acc <= '0;
                        r_k   <= 2'd0;
                        r_ph  <= 1'b0;
                        if (i_req.op == ALU_LN) begin
                            r_m     <= i_req.a[XW-1:0];
                            r_e     <= EXP_W'(XW - 1);
                            r_state <= A_NORM;
                        end else begin
                            r_a64   <= i_req.a;
                            r_b64   <= i_req.b;
                            r_state <= A_MUL;
                        end
                    end
                end
                A_NORM: begin
                    if (r_m[XW-1]) begin
                        r_mant  <= mant_init;
                        r_frac  <= '0;
                        r_cnt   <= 6'd0;
                        r_ph    <= 1'b0;
                        r_state <= A_SQ;
                    end else begin
                        r_m <= r_m << 1;
                        r_e <= r_e - EXP_W'(1);
                    end
                end
                A_SQ: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_mant <= n_mant;
                        r_frac <= n_frac;
                        r_cnt  <= r_cnt + 6'd1;
                        if (r_cnt == 6'(LOG2_FRAC - 1)) begin
                            r_a64   <= 64'({r_e, n_frac});
                            r_b64   <= LN2_Q63;
                            r_acc   <= '0;
                            r_k     <= 2'd0;
                            r_state <= A_MUL;
                        end
                    end
                end
                A_MUL: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc <= r_acc + part;
                        r_k   <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_state <= A_FIN;
                        end
                    end
                end
                A_FIN: begin
                    r_rsp.done  <= 1'b1;
                    r_rsp.value <= (r_op == ALU_LN) ? ln_val : mul_val;
                    r_state     <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp = r_rsp;

endmodule

[src/binomial_row_deviance.sv]
// Top level: row sums, entropy sequencer and result register.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  input   | i_valid o_ready i_success_count i_failure_count  | in
//          | i_row_end                                        |
//  result  | o_valid i_ready o_deviance o_overflowed          | out
//
// One element takes up to three logarithms and two wide products on one
// shared 32x32 multiplier: a log normalizes its XW-bit argument, then runs
// 40 squarings and four partial products; a product runs four partial
// products. An element with both counts zero takes no logarithm. A row end
// adds one more such pass on the row sums unless a sum or the accumulator
// saturated or the row is degenerate. Reset clears the sums and o_valid.
// A result that is not taken holds the block before it starts a new one.
module binomial_row_deviance
    import brd_pkg::*;
#(
    parameter int COUNT_BITS    = 16,
    parameter int LOG_FRAC_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [COUNT_BITS-1:0] i_success_count,
    input  logic [COUNT_BITS-1:0] i_failure_count,
    input  logic                  i_row_end,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DEV_W-1:0]      o_deviance,
    output logic                  o_overflowed
);

    localparam int XW  = (COUNT_BITS + 1 > SUM_N_W) ? COUNT_BITS + 1 : SUM_N_W;
    localparam int SH  = LOG_FRAC_BITS - 17;
    localparam int SHP = (SH > 0) ? SH : 1;
    localparam int KN  = (SH < 0) ? -SH : 0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T,
        S_A,
        S_MA,
        S_B,
        S_MB,
        S_END,
        S_FIN,
        S_RND,
        S_OUT
    } t_state;

    t_state             r_state;
    logic               r_wait;
    logic [XW-1:0]      r_a;
    logic [XW-1:0]      r_b;
    logic [63:0]        r_lt;
    logic [63:0]        r_tmp;
    logic [63:0]        r_r;
    logic [SUM_Y_W-1:0] r_ss;
    logic [SUM_N_W-1:0] r_ts;
    logic [ACC_W-1:0]   r_acc;
    logic               r_last;
    logic               r_final;
    logic [DEV_W-1:0]   r_dev;
    logic               r_ovf;
    t_alu_req           r_req;
    t_alu_rsp           rsp;
    logic               r_out_valid;
    logic [DEV_W-1:0]   r_out_dev;
    logic               r_out_ovf;

    logic [XW-1:0]      t_sum;
    logic [64:0]        part_sum;
    logic [64:0]        acc_sum;
    logic [ACC_W-1:0]   acc_next;
    logic [XW:0]        ss_sum;
    logic [XW:0]        ts_sum;
    logic [SUM_Y_W-1:0] ss_next;
    logic [SUM_N_W-1:0] ts_next;
    logic [63:0]        diff;
    logic [64:0]        rnd_sum;
    logic [63:0]        dv;
    logic               dv_ovf;
    logic               sat_hit;
    logic               nondeg;

    brd_alu #(
        .XW            (XW),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (rsp)
    );

    always_comb begin
        t_sum    = r_a + r_b;
        part_sum = {1'b0, r_r} + {1'b0, rsp.value};
        acc_sum  = 65'(r_acc) + {1'b0, r_r};
        acc_next = (acc_sum > 65'(ACC_MAX)) ? ACC_MAX[ACC_W-1:0] : acc_sum[ACC_W-1:0];
        ss_sum   = (XW+1)'(r_ss) + (XW+1)'(i_success_count);
        ts_sum   = (XW+1)'(r_ts) + (XW+1)'(i_success_count) + (XW+1)'(i_failure_count);
        ss_next  = (ss_sum > (XW+1)'(SUM_Y_MAX)) ? SUM_Y_MAX[SUM_Y_W-1:0]
                                                 : ss_sum[SUM_Y_W-1:0];
        ts_next  = (ts_sum > (XW+1)'(SUM_N_MAX)) ? SUM_N_MAX[SUM_N_W-1:0]
                                                 : ts_sum[SUM_N_W-1:0];
        sat_hit  = (64'(r_ss) == SUM_Y_MAX) || (64'(r_ts) == SUM_N_MAX)
                || (64'(r_acc) == ACC_MAX);
        nondeg   = (r_ts != '0) && (r_ss != '0) && (SUM_N_W'(r_ss) != r_ts);
        diff     = (r_r > 64'(r_acc)) ? r_r - 64'(r_acc) : 64'd0;
        rnd_sum  = {1'b0, diff} + 65'(64'd1 << (SHP - 1));
        if (SH > 0) begin
            dv = (rnd_sum[64] ? '1 : rnd_sum[63:0]) >> SHP;
        end else if (SH == 0) begin
            dv = diff;
        end else begin
            dv = (diff > (DEV_MAX >> KN)) ? '1 : (diff << KN);
        end
        dv_ovf = dv > DEV_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_req.start <= 1'b0;
            r_ss        <= '0;
            r_ts        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_a     <= XW'(i_success_count);
                        r_b     <= XW'(i_failure_count);
                        r_ss    <= ss_next;
                        r_ts    <= ts_next;
                        r_last  <= i_row_end;
                        r_final <= 1'b0;
                        r_state <= S_T;
                    end
                end
                S_T: begin
                    if (!r_wait) begin
                        if (t_sum == '0) begin
                            r_r     <= 64'd0;
                            r_state <= S_END;
                        end else begin
                            r_req  <= '{1'b1, ALU_LN, 64'(t_sum), 64'd0};
                            r_wait <= 1'b1;
                        end
                    end else if (rsp.done) begin
                        r_wait  <= 1'b0;
                        r_lt    <= rsp.value;
                        r_r     <= 64'd0;
                        r_state <= S_A;
                    end
                end
                S_A: begin
                    if (!r_wait) begin
                        if (r_a == '0) begin
                            r_state <= S_B;
                        end else begin
                            r_req  <= '{1'b1, ALU_LN, 64'(r_a), 64'd0};
                            r_wait <= 1'b1;
                        end
                    end else if (rsp.done) begin
                        r_wait  <= 1'b0;
                        r_tmp   <= r_lt - rsp.value;
                        r_state <= S_MA;
                    end
                end
                S_MA: begin
                    if (!r_wait) begin
                        r_req  <= '{1'b1, ALU_MUL, 64'(r_a), r_tmp};
                        r_wait <= 1'b1;
                    end else if (rsp.done) begin
                        r_wait  <= 1'b0;
                        r_r     <= rsp.value;
                        r_state <= S_B;
                    end
                end
                S_B: begin
                    if (!r_wait) begin
                        if (r_b == '0) begin
                            r_state <= S_END;
                        end else begin
                            r_req  <= '{1'b1, ALU_LN, 64'(r_b), 64'd0};
                            r_wait <= 1'b1;
                        end
                    end else if (rsp.done) begin
                        r_wait  <= 1'b0;
                        r_tmp   <= r_lt - rsp.value;
                        r_state <= S_MB;
                    end
                end
                S_MB: begin
                    if (!r_wait) begin
                        r_req  <= '{1'b1, ALU_MUL, 64'(r_b), r_tmp};
                        r_wait <= 1'b1;
                    end else if (rsp.done) begin
                        r_wait  <= 1'b0;
                        r_r     <= part_sum[64] ? '1 : part_sum[63:0];
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (r_final) begin
                        r_state <= S_RND;
                    end else begin
                        r_acc   <= acc_next;
                        r_state <= r_last ? S_FIN : S_IDLE;
                    end
                end
                S_FIN: begin
                    if (sat_hit) begin
                        r_dev   <= DEV_MAX[DEV_W-1:0];
                        r_ovf   <= 1'b1;
                        r_state <= S_OUT;
                    end else if (nondeg) begin
                        r_a     <= XW'(r_ss);
                        r_b     <= XW'(r_ts - SUM_N_W'(r_ss));
                        r_final <= 1'b1;
                        r_state <= S_T;
                    end else begin
                        r_dev   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_RND: begin
                    r_dev   <= dv_ovf ? DEV_MAX[DEV_W-1:0] : dv[DEV_W-1:0];
                    r_ovf   <= dv_ovf;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_dev   <= r_dev;
                        r_out_ovf   <= r_ovf;
                        r_ss        <= '0;
                        r_ts        <= '0;
                        r_acc       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_deviance   = r_out_dev;
    assign o_overflowed = r_out_ovf;

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("block ready right after taking an element");

    a_rsp_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> r_wait)
        else $error("unit answered with no request pending");

    a_ovf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflowed) |-> (64'(o_deviance) == DEV_MAX))
        else $error("overflow flagged below the maximum");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

endmodule
